// ===== hw/rtl/sha256_message_hash_defines.svh =====
// Assertion macros shared by the checker.
`ifndef SHA256_MESSAGE_HASH_DEFINES_SVH
`define SHA256_MESSAGE_HASH_DEFINES_SVH
// Assert that a implies b in the next cycle.
`define SHA_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("check failed: label");
// Assert that a implies b in the same cycle.
`define SHA_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("check failed: label");
`endif

// ===== hw/rtl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Mode codes, queue entry, initial hash words, round constants and a rotate function.
// ----------------------------------------------------------------------------
package sha_pkg;
  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_APPEND_FINISH = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int QUEUE_DEPTH = 4;

  // Queue entry from the front part to the engine.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       finish;
  } cmd_t;

  function automatic logic [31:0] initial_hash(input logic [2:0] i);
    logic [31:0] r;
    unique case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  localparam logic [31:0] K_ROM [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int k);
    return (v >> k) | (v << (32 - k));
  endfunction
endpackage

// ===== hw/rtl/sha_front.sv =====
// ----------------------------------------------------------------------------
// SHA-256 front part
// Classifies each command beat and queues the ones that carry work for the engine.
// ----------------------------------------------------------------------------
module sha_front #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    mode,
  input  logic [7:0]    data_byte,
  output logic          full,
  output logic          q_valid,
  output sha_pkg::cmd_t q_cmd,
  input  logic          q_pop
);
  import sha_pkg::*;
  localparam int AW = $clog2(DEPTH);

  cmd_t             mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;
  logic             push;
  cmd_t             cmd;

  // Mode three carries no work and is dropped here.
  always_comb begin
    cmd.data = data_byte;
    cmd.has_byte = (mode == MODE_APPEND) || (mode == MODE_APPEND_FINISH);
    cmd.finish = (mode == MODE_APPEND_FINISH) || (mode == MODE_FINISH);
  end
  assign full = (count == (AW + 1)'(DEPTH));
  assign push = start && !full && (cmd.has_byte || cmd.finish);
  assign q_valid = (count != '0);
  assign q_cmd = mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= cmd;
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW + 1)'(push) - (AW + 1)'(q_pop);
    end
  end
endmodule

// ===== hw/rtl/sha_engine.sv =====
// ----------------------------------------------------------------------------
// SHA-256 engine
// Fills the block buffer, pads, runs 64 rounds per block and emits the digest.
// ----------------------------------------------------------------------------
module sha_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  sha_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          done,
  output logic [31:0]   digest_word,
  output logic [2:0]    word_index,
  output logic          is_last
);
  import sha_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_ADD   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t      state;
  logic [31:0] w [16];
  logic [31:0] h [8];
  logic [31:0] a, b, c, d, e, f, g, hh;
  logic [60:0] byte_count;
  logic [5:0]  fill;
  logic [5:0]  round;
  logic [2:0]  out_idx;
  logic        finishing;
  logic        pad_zero;
  logic        pad_final;
  logic        idle;
  logic [31:0] wt, w_new, t1, t2, s0, s1, ch, mj, sg0, sg1;
  logic [63:0] bits;
  logic [7:0]  wr_byte;
  logic [1:0]  lane;

  assign bits = {byte_count, 3'b000};
  assign lane = fill[1:0];
  assign idle = (state == S_IDLE);
  assign q_pop = idle && q_valid;

  // Schedule and round datapath.
  always_comb begin
    sg0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    sg1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + sg0 + w[9] + sg1;
    wt = w[0];
    s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    ch = (e & f) ^ (~e & g);
    t1 = hh + s1 + ch + K_ROM[round] + wt;
    s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    mj = (a & b) ^ (a & c) ^ (b & c);
    t2 = s0 + mj;
  end

  // Byte placed by a padding step.
  always_comb begin
    if (!pad_final) wr_byte = 8'h00;
    else if (fill == 6'd55 || fill < 6'd56) wr_byte = 8'h00;
    else wr_byte = bits[6'(63 - 8 * (int'(fill) - 56)) -: 8];
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      byte_count <= '0;
      fill <= '0;
      round <= '0;
      out_idx <= '0;
      finishing <= 1'b0;
      pad_zero <= 1'b0;
      pad_final <= 1'b0;
      done <= 1'b0;
      for (int i = 0; i < 8; i++) h[i] <= initial_hash(3'(i));
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            finishing <= q_cmd.finish;
            if (q_cmd.has_byte) begin
              w[fill[5:2]][5'(31 - 8 * lane) -: 8] <= q_cmd.data;
              byte_count <= byte_count + 61'd1;
              fill <= fill + 6'd1;
              if (fill == 6'd63) begin
                state <= S_ROUND;
                pad_final <= 1'b0;
              end else if (q_cmd.finish) state <= S_PAD;
              // The finish marker byte goes in next.
            end else begin
              state <= S_PAD;
            end
            if (q_cmd.finish) pad_final <= 1'b0;
            round <= '0;
            {a, b, c, d, e, f, g, hh} <= {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
          end
        end
        // Padding: first step writes 0x80, then zeros, then the length.
        S_PAD: begin
          if (finishing) begin
            w[fill[5:2]][5'(31 - 8 * lane) -: 8] <= 8'h80;
            finishing <= 1'b0;
            fill <= fill + 6'd1;
            // A marker at offset 56 or later leaves no room for the length.
            if (fill == 6'd63) begin
              state <= S_ROUND;
              pad_zero <= 1'b1;
            end else if (fill >= 6'd56) begin
              pad_zero <= 1'b1;
            end else begin
              pad_final <= 1'b1;
            end
          end else if (!pad_final) begin
            // Zero fill of the block that holds the marker.
            w[fill[5:2]][5'(31 - 8 * lane) -: 8] <= 8'h00;
            fill <= fill + 6'd1;
            if (fill == 6'd63) state <= S_ROUND;
          end else begin
            w[fill[5:2]][5'(31 - 8 * lane) -: 8] <= wr_byte;
            fill <= fill + 6'd1;
            if (fill == 6'd63) state <= S_ROUND;
          end
          {a, b, c, d, e, f, g, hh} <= {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
          round <= '0;
        end
        // One round per cycle; the schedule window shifts each round.
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          w[15] <= w_new;
          {b, c, d} <= {a, b, c};
          {f, g, hh} <= {e, f, g};
          e <= d + t1;
          a <= t1 + t2;
          round <= round + 6'd1;
          if (round == 6'd63) state <= S_ADD;
        end
        S_ADD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c; h[3] <= h[3] + d;
          h[4] <= h[4] + e; h[5] <= h[5] + f; h[6] <= h[6] + g; h[7] <= h[7] + hh;
          fill <= '0;
          if (pad_final) begin
            state <= S_OUT;
            out_idx <= '0;
          end else if (finishing) begin
            state <= S_PAD;
          end else if (pad_zero) begin
            // The extra block carries zeros and the length.
            state <= S_PAD;
            pad_zero <= 1'b0;
            pad_final <= 1'b1;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          done <= 1'b1;
          digest_word <= h[out_idx];
          word_index <= out_idx;
          is_last <= (out_idx == 3'd7);
          h[out_idx] <= initial_hash(out_idx);
          out_idx <= out_idx + 3'd1;
          if (out_idx == 3'd7) begin
            state <= S_IDLE;
            byte_count <= '0;
            pad_final <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/sha256_message_hash.sv =====
// An append beat is absorbed by the engine; one that completes a block also runs its rounds.
// A finish takes the padding steps and the rounds of each remaining block, then
// the eight digest words, one per output beat; the single round unit sets the pace.
// Bytes queue up while the engine works; busy holds them back while the queue is full. The receiver cannot stall.
// Synchronous reset restores the initial hash words and empties the count and queue.
// ----------------------------------------------------------------------------
// SHA-256 message hash
// Byte-fed hash with a command queue in front of a round engine.
// ----------------------------------------------------------------------------
module sha256_message_hash #(
  parameter int QDEPTH = sha_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  data_byte,
  output logic        done,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        is_last
);
  import sha_pkg::*;

  logic full, q_valid, q_pop;
  cmd_t q_cmd;

  assign busy = full;

  sha_front #(.DEPTH(QDEPTH)) u_front (
    .clk, .rst, .start, .mode, .data_byte, .full, .q_valid, .q_cmd, .q_pop
  );

  sha_engine u_engine (
    .clk, .rst, .q_valid, .q_cmd, .q_pop, .done, .digest_word, .word_index, .is_last
  );
endmodule

// ===== hw/rtl/sha_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Watches the output beats of the top level.
// ----------------------------------------------------------------------------
`include "sha256_message_hash_defines.svh"
module sha_checker (
  input logic        clk,
  input logic        rst,
  input logic        done,
  input logic [2:0]  word_index,
  input logic        is_last
);
  // Words come out in order, the last one marked.
  `SHA_ASSERT_NOW(last_on_seven, clk, rst, done, is_last == (word_index == 3'd7))
  `SHA_ASSERT_NEXT(words_follow, clk, rst, done && !is_last, done)
  `SHA_ASSERT_NEXT(index_steps, clk, rst, done && !is_last, word_index == $past(word_index) + 3'd1)
endmodule

bind sha256_message_hash sha_checker u_checker (
  .clk, .rst, .done, .word_index, .is_last
);

// ===== verif/sha256_message_hash_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 message hash checker
// Watches command beats and digest words, computes the expected digest of
// each message and compares every word as it arrives.
// ----------------------------------------------------------------------------
module sha256_message_hash_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  data_byte,
  input  logic        done,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        is_last,
  output int          fail_count,
  output int          pending_words
);
  import sha_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [7:0]  msg_block [64];
  logic [31:0] chain [8];
  logic [60:0] msg_bytes;
  int          fill;
  digest_beat_t digest_queue [$];

  function automatic logic [31:0] ror32(input logic [31:0] v, input int k);
    return (v >> k) | (v << (32 - k));
  endfunction

  // One full compression of the current block into the chaining value.
  task automatic compress();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2, x15, x2;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int j = 0; j < 8; j++) v[j] = chain[j];
    for (int t = 0; t < 64; t++) begin
      if (t >= 16) begin
        x15 = w[(t - 15) & 15];
        x2 = w[(t - 2) & 15];
        w[t & 15] = w[t & 15] + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3)) +
                    w[(t - 7) & 15] + (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10));
      end
      s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
      t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_ROM[t] + w[t & 15];
      s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
      t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) chain[j] += v[j];
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    msg_block[fill] = b;
    fill++;
    msg_bytes++;
    if (fill == 64) begin
      compress();
      fill = 0;
    end
  endtask

  // Pad, compress the tail and queue the eight digest words.
  task automatic close_message();
    logic [63:0] bit_len;
    digest_beat_t d;
    bit_len = {msg_bytes, 3'b000};
    msg_block[fill] = 8'h80;
    fill++;
    if (fill > 56) begin
      while (fill < 64) begin msg_block[fill] = 8'h00; fill++; end
      compress();
      fill = 0;
    end
    while (fill < 56) begin msg_block[fill] = 8'h00; fill++; end
    for (int i = 0; i < 8; i++) msg_block[56 + i] = bit_len[63 - 8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      d.word = chain[i];
      d.index = i[2:0];
      d.last = (i == 7);
      digest_queue = {digest_queue, d};
    end
    for (int j = 0; j < 8; j++) chain[j] = H_INIT[j];
    msg_bytes = '0;
    fill = 0;
  endtask

  // Command beats update the prediction; digest beats are checked in order.
  always @(posedge clk) begin
    digest_beat_t exp_beat;
    if (rst) begin
      for (int j = 0; j < 8; j++) chain[j] = H_INIT[j];
      msg_bytes = '0;
      fill = 0;
      digest_queue.delete();
      fail_count = 0;
    end else begin
      if (done) begin
        if (digest_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Unexpected digest beat: word %h index %0d last %0b",
                     digest_word, word_index, is_last);
        end else begin
          exp_beat = digest_queue.pop_front();
          if (digest_word !== exp_beat.word || word_index !== exp_beat.index ||
              is_last !== exp_beat.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                       exp_beat.word, exp_beat.index, exp_beat.last,
                       digest_word, word_index, is_last);
          end
        end
      end
      if (start && !busy) begin
        case (mode)
          MODE_APPEND: absorb_byte(data_byte);
          MODE_APPEND_FINISH: begin
            absorb_byte(data_byte);
            close_message();
          end
          MODE_FINISH: close_message();
          default: ;
        endcase
      end
    end
    pending_words = digest_queue.size();
  end
endmodule

// ===== verif/tb_sha256_message_hash.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 message hash testbench
// Feeds directed and random byte messages with random idle bursts and lets
// the checker compare every digest word with its own SHA-256 computation.
// ----------------------------------------------------------------------------
module tb_sha256_message_hash;
  import sha_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  mode;
  logic [7:0]  data_byte;
  logic        done;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        is_last;
  int          fail_count;
  int          pending_words;
  int          cycle_count;
  bit          gaps_on;

  sha256_message_hash dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .data_byte(data_byte), .done(done), .digest_word(digest_word),
    .word_index(word_index), .is_last(is_last)
  );

  sha256_message_hash_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .data_byte(data_byte), .done(done), .digest_word(digest_word),
    .word_index(word_index), .is_last(is_last),
    .fail_count(fail_count), .pending_words(pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on total run length.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Drive one command beat at a falling edge and hold it until the block takes it.
  // Busy only changes after a rising edge, so its value at the falling edge
  // decides the next rising edge.
  task automatic send_beat(input logic [1:0] m, input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    start <= 1'b1;
    mode <= m;
    data_byte <= b;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  // A message of n random bytes closed by the given finish style.
  task automatic send_message(input int n, input bit finish_with_byte);
    for (int i = 0; i < n - (finish_with_byte ? 1 : 0); i++)
      send_beat(MODE_APPEND, 8'($urandom));
    if (finish_with_byte) send_beat(MODE_APPEND_FINISH, 8'($urandom));
    else send_beat(MODE_FINISH, 8'h00);
  endtask

  initial begin
    int len;
    start = 1'b0;
    mode = MODE_APPEND;
    data_byte = 8'h00;
    gaps_on = 1'b1;
    rst = 1'b1;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty message, unused mode, byte extremes, padding edges.
    send_beat(MODE_FINISH, 8'hff);
    send_beat(MODE_UNUSED, 8'hff);
    send_beat(MODE_APPEND_FINISH, 8'h00);
    send_beat(MODE_APPEND, 8'hff);
    send_beat(MODE_UNUSED, 8'h5a);
    send_beat(MODE_APPEND_FINISH, 8'hff);
    send_message(3, 1'b0);

    // A full data block, then a tail whose marker lands at offset 56 and
    // pushes the length into an extra block.
    send_message(120, 1'b0);

    // Random short messages with no idling at the end of the run.
    gaps_on = 1'b0;
    for (int k = 0; k < 3; k++) begin
      len = $urandom_range(1, 4);
      if ($urandom_range(0, 4) == 0) send_beat(MODE_UNUSED, 8'($urandom));
      send_message(len, 1'($urandom_range(0, 1)));
    end
    start <= 1'b0;

    while (pending_words != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
